### rtl/cq_pkg.sv
// shared constants and types for the circular queue with dump
package cq_pkg;

    // field widths
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int QSIZE_W  = 5;

    // default storage depth and queue_size after reset
    localparam int DEPTH_DEF = 16;
    localparam logic [QSIZE_W-1:0] QSIZE_RST = 5'd16;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

### rtl/circular_queue_with_dump.sv
// top level of the circular queue with dump
//
// Circular queue of signed 32-bit words kept in a one-port-read ram.
// Input channel (in_valid/in_ready) carries func and value: insert, remove
// oldest, or dump every stored word oldest first. Output channel
// (out_valid/out_ready) returns status, data and last per result word;
// last marks the final word caused by one input word.
// The cfg_we/cfg_wdata port writes queue_size (clamped to 1..DEPTH) and
// empties the queue; write it only while the block is idle.
// Insert and every error load the output register directly on acceptance; a
// remove or dump word passes through the ram's read register and then the
// output register, and a dump then gives one word per cycle while the
// receiver does not stall. Inserts and errors are accepted every cycle while
// the output register is free; a remove or dump holds in_ready low until its
// final word enters the output register.
// Reset empties the queue and sets queue_size to 16 (DEPTH if smaller); the ram is not cleared.
// When the receiver stalls, the output register holds its word, the dump
// sequencer pauses and in_ready stays low until the register frees up.
module circular_queue_with_dump #(
    parameter int DEPTH = cq_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cq_pkg::FUNC_W-1:0]        func,
    input  logic signed [cq_pkg::DATA_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cq_pkg::STATUS_W-1:0]      status,
    output logic signed [cq_pkg::DATA_W-1:0] data,
    output logic                             last,
    input  logic                             cfg_we,
    input  logic [cq_pkg::QSIZE_W-1:0]       cfg_wdata
);

    localparam int PW = $clog2(DEPTH);

    logic                      ram_we;
    logic [PW-1:0]             ram_waddr;
    logic [cq_pkg::DATA_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [PW-1:0]             ram_raddr;
    logic [cq_pkg::DATA_W-1:0] ram_rdata;

    // controller
    cq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // entry storage
    cq_ram #(
        .WIDTH (cq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

### rtl/cq_ram.sv
// generic single-write, single-read ram with registered read data
module cq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/cq_ctrl.sv
// queue controller: pointers, fill count, dump sequencer and output register
module cq_ctrl #(
    parameter int DEPTH = cq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cq_pkg::FUNC_W-1:0]     func,
    input  logic signed [cq_pkg::DATA_W-1:0] value,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cq_pkg::STATUS_W-1:0]   status,
    output logic signed [cq_pkg::DATA_W-1:0] data,
    output logic                          last,
    // configuration
    input  logic                          cfg_we,
    input  logic [cq_pkg::QSIZE_W-1:0]    cfg_wdata,
    // ram side
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [cq_pkg::DATA_W-1:0]     ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [cq_pkg::DATA_W-1:0]     ram_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = PW + 1;
    localparam int MW = (CW > cq_pkg::QSIZE_W) ? CW : cq_pkg::QSIZE_W;
    localparam int CAP_RST_I = (int'(cq_pkg::QSIZE_RST) > DEPTH) ? DEPTH
                                                                 : int'(cq_pkg::QSIZE_RST);
    localparam logic [CW-1:0] CAP_RST = CW'(CAP_RST_I);

    cq_pkg::state_t state_reg, state_next;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] rem_reg, rem_next;

    logic                            out_valid_reg, out_valid_next;
    logic [cq_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [cq_pkg::DATA_W-1:0]       out_data_reg, out_data_next;
    logic                            out_last_reg, out_last_next;

    logic out_free;
    logic accept;
    logic is_full;
    logic is_empty;

    // pointer step with wrap at the capacity in use
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [CW-1:0] cap);
        logic [CW-1:0] n;
        n = {1'b0, p} + CW'(1);
        return (n >= cap) ? '0 : n[PW-1:0];
    endfunction

    // queue_size clamped to 1..DEPTH
    function automatic logic [CW-1:0] clamp_cap(input logic [cq_pkg::QSIZE_W-1:0] qs);
        logic [MW-1:0] qx;
        qx = MW'(qs);
        if (qx == '0)
            return CW'(1);
        else if (qx > MW'(DEPTH))
            return CW'(DEPTH);
        else
            return qx[CW-1:0];
    endfunction

    // handshake and status terms
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == cq_pkg::ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign is_full  = fill_reg >= cap_reg;
    assign is_empty = fill_reg == '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cq_pkg::ST_IDLE:
            begin
                if (accept && !is_empty &&
                    (func == cq_pkg::FN_REMOVE || func == cq_pkg::FN_DUMP))
                begin
                    state_next = cq_pkg::ST_RUN;
                end
            end
            cq_pkg::ST_RUN:
            begin
                if (out_free && rem_reg == CW'(1))
                begin
                    state_next = cq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, ram control and output register load
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        ptr_next        = ptr_reg;
        fill_next       = fill_reg;
        cap_next        = cap_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata       = value;
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg;

        if (cfg_we)
        begin
            cap_next  = clamp_cap(cfg_wdata);
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end
        else
        begin
            unique case (state_reg)
                cq_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (func)
                            cq_pkg::FN_INSERT:
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                                out_last_next  = 1'b1;
                                if (is_full)
                                begin
                                    out_status_next = cq_pkg::STAT_OVERFLOW;
                                end
                                else
                                begin
                                    out_status_next = cq_pkg::STAT_OK;
                                    ram_we          = 1'b1;
                                    tail_next       = advance(tail_reg, cap_reg);
                                    fill_next       = fill_reg + CW'(1);
                                end
                            end
                            cq_pkg::FN_REMOVE:
                            begin
                                if (is_empty)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = cq_pkg::STAT_UNDERFLOW;
                                    out_data_next   = '0;
                                    out_last_next   = 1'b1;
                                end
                                else
                                begin
                                    ram_re    = 1'b1;
                                    ram_raddr = head_reg;
                                    head_next = advance(head_reg, cap_reg);
                                    fill_next = fill_reg - CW'(1);
                                    rem_next  = CW'(1);
                                end
                            end
                            cq_pkg::FN_DUMP:
                            begin
                                if (is_empty)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = cq_pkg::STAT_UNDERFLOW;
                                    out_data_next   = '0;
                                    out_last_next   = 1'b1;
                                end
                                else
                                begin
                                    ram_re    = 1'b1;
                                    ram_raddr = head_reg;
                                    ptr_next  = advance(head_reg, cap_reg);
                                    rem_next  = fill_reg;
                                end
                            end
                            default:
                            begin
                                // unused code: word dropped, no result
                            end
                        endcase
                    end
                end
                cq_pkg::ST_RUN:
                begin
                    // hand the read word to the output register, fetch the next one if any remain
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = cq_pkg::STAT_OK;
                        out_data_next   = ram_rdata;
                        out_last_next   = rem_reg == CW'(1);
                        rem_next        = rem_reg - CW'(1);
                        if (rem_reg != CW'(1))
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = ptr_reg;
                            ptr_next  = advance(ptr_reg, cap_reg);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cq_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            cap_reg       <= CAP_RST;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            cap_reg       <= cap_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign last      = out_last_reg;

    // checks
    a_fill_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap_reg)
        else $error("fill count above capacity");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, head_reg} < cap_reg) && ({1'b0, tail_reg} < cap_reg))
        else $error("pointer outside capacity");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == cq_pkg::FN_INSERT && !is_full && !cfg_we)
        |=> fill_reg == $past(fill_reg) + CW'(1))
        else $error("insert did not grow fill count");

    a_run_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cq_pkg::ST_RUN) |-> (rem_reg != '0))
        else $error("run state with nothing left to send");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cq_pkg::ST_RUN && out_free && rem_reg == CW'(1))
        |=> (state_reg == cq_pkg::ST_IDLE && out_valid_reg && out_last_reg))
        else $error("final word not marked last or sequencer did not stop");

endmodule
